// ===== rtl/alid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alid_pkg
// Shared types, sizes and codes for the fixed-capacity ordered entry list.
// ----------------------------------------------------------------------------
package alid_pkg;

    // capacity and stored field widths
    localparam int DEPTH      = 16;
    localparam int KEY_WIDTH  = 32;
    localparam int DATA_WIDTH = 32;

    // fixed item field widths
    localparam int REQ_W   = 2;
    localparam int POS_W   = 5;
    localparam int KEYIN_W = 32;
    localparam int DATIN_W = 32;
    localparam int ST_W    = 3;
    localparam int FND_W   = 5;
    localparam int CNTO_W  = 5;

    // derived sizes
    localparam int ENTRY_W = KEY_WIDTH + DATA_WIDTH;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CW      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_SEARCH = 2'd3
    } req_t;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // controller to datapath commands
    typedef struct packed {
        logic    load;         // capture the incoming item
        logic    append;       // write new entry at the tail, count up
        logic    put_new;      // write new entry at the position, count up
        logic    dec_cnt;      // count down
        logic    init_up;      // read pointer to last entry
        logic    init_down;    // read pointer to position plus one
        logic    init_search;  // read pointer to first entry
        logic    move_up;      // read entry, schedule write one slot higher
        logic    move_down;    // read entry, schedule write one slot lower
        logic    search_read;  // read entry for key compare
        logic    res_set;      // latch result status
        status_t res_status;
        logic    res_found;    // report the compared slot as the match
        logic    emit;         // load output register
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        req_t req;
        logic full;
        logic empty;
        logic ins_bad;
        logic ins_moves;
        logic del_bad;
        logic del_moves;
        logic ra_at_pos;
        logic ra_at_end;
        logic hit;
        logic out_busy;
    } dp_stat_t;

endpackage

// ===== rtl/alid_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alid_dp
// Datapath: entry memory, fill count, shift and search pointers, output item.
// ----------------------------------------------------------------------------
module alid_dp (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  alid_pkg::ctrl_cmd_t       cmd,
    output alid_pkg::dp_stat_t        stat,
    input  alid_pkg::req_t            in_req,
    input  logic [alid_pkg::POS_W-1:0]   in_pos,
    input  logic [alid_pkg::KEYIN_W-1:0] in_key,
    input  logic [alid_pkg::DATIN_W-1:0] in_data,
    input  logic                      m_ready,
    output logic                      m_valid,
    output logic [alid_pkg::ST_W-1:0]    m_status,
    output logic [alid_pkg::FND_W-1:0]   m_found,
    output logic [alid_pkg::CNTO_W-1:0]  m_count
);
    import alid_pkg::*;

    logic [ENTRY_W-1:0]    mem [DEPTH];

    req_t                  req_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [KEY_WIDTH-1:0]  key_reg;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [IDX_W-1:0]      ra_reg;
    logic [IDX_W-1:0]      wa_reg;
    logic                  wpend_reg;
    logic [ENTRY_W-1:0]    rd_reg;
    logic                  cmp_valid_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    status_t               res_st_reg;
    logic [FND_W-1:0]      res_fnd_reg;
    logic                  out_valid_reg;
    logic [ST_W-1:0]       out_st_reg;
    logic [FND_W-1:0]      out_fnd_reg;
    logic [CNTO_W-1:0]     out_cnt_reg;

    logic [CW-1:0]         cnt_x;
    logic [CW-1:0]         pos_x;
    logic [CW-1:0]         pos_p1;
    logic [CW-1:0]         ra_p1;
    logic [CW-1:0]         fnd_x;
    logic [CW-1:0]         cnt_m1;

    // widened compare operands
    assign cnt_x  = CW'(cnt_reg);
    assign pos_x  = CW'(pos_reg);
    assign pos_p1 = pos_x + CW'(1);
    assign ra_p1  = CW'(ra_reg) + CW'(1);
    assign fnd_x  = CW'(cmp_idx_reg) + CW'(1);
    assign cnt_m1 = cnt_x - CW'(1);

    // status toward the controller
    always_comb begin
        stat.req       = req_reg;
        stat.full      = (cnt_x == CW'(DEPTH));
        stat.empty     = (cnt_x == '0);
        stat.ins_bad   = (pos_x > cnt_x);
        stat.ins_moves = (pos_x < cnt_x);
        stat.del_bad   = (pos_x >= cnt_x);
        stat.del_moves = (pos_p1 < cnt_x);
        stat.ra_at_pos = (CW'(ra_reg) == pos_x);
        stat.ra_at_end = (ra_p1 == cnt_x);
        stat.hit       = cmp_valid_reg && (rd_reg[KEY_WIDTH-1:0] == key_reg);
        stat.out_busy  = out_valid_reg && !m_ready;
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= in_req;
            pos_reg  <= in_pos;
            key_reg  <= in_key[KEY_WIDTH-1:0];
            data_reg <= in_data[DATA_WIDTH-1:0];
        end
    end

    // fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.append || cmd.put_new) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end else if (cmd.dec_cnt) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // read pointer, pending write and compare tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpend_reg     <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end else begin
            wpend_reg     <= cmd.move_up || cmd.move_down;
            cmp_valid_reg <= cmd.search_read;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.init_up) begin
            ra_reg <= cnt_m1[IDX_W-1:0];
        end else if (cmd.init_down) begin
            ra_reg <= pos_p1[IDX_W-1:0];
        end else if (cmd.init_search) begin
            ra_reg <= '0;
        end else if (cmd.move_up) begin
            ra_reg <= ra_reg - IDX_W'(1);
        end else if (cmd.move_down || cmd.search_read) begin
            ra_reg <= ra_reg + IDX_W'(1);
        end
        if (cmd.move_up) begin
            wa_reg <= ra_reg + IDX_W'(1);
        end else if (cmd.move_down) begin
            wa_reg <= ra_reg - IDX_W'(1);
        end
        if (cmd.search_read) begin
            cmp_idx_reg <= ra_reg;
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.move_up || cmd.move_down || cmd.search_read) begin
            rd_reg <= mem[ra_reg];
        end
        if (wpend_reg) begin
            mem[wa_reg] <= rd_reg;
        end else if (cmd.append) begin
            mem[cnt_reg[IDX_W-1:0]] <= {data_reg, key_reg};
        end else if (cmd.put_new) begin
            mem[pos_x[IDX_W-1:0]] <= {data_reg, key_reg};
        end
    end

    // result latch
    always_ff @(posedge aclk) begin
        if (cmd.res_set) begin
            res_st_reg  <= cmd.res_status;
            res_fnd_reg <= cmd.res_found ? fnd_x[FND_W-1:0] : '0;
        end
    end

    // output item register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_st_reg  <= res_st_reg;
            out_fnd_reg <= res_fnd_reg;
            out_cnt_reg <= cnt_x[CNTO_W-1:0];
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_status = out_st_reg;
    assign m_found  = out_fnd_reg;
    assign m_count  = out_cnt_reg;

endmodule

// ===== rtl/alid_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alid_ctrl
// Controller: decodes each request and sequences shifts, searches and results.
// ----------------------------------------------------------------------------
module alid_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  alid_pkg::dp_stat_t  stat,
    output alid_pkg::ctrl_cmd_t cmd
);
    import alid_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_UP,
        S_UP_WAIT,
        S_PUT,
        S_DOWN,
        S_DOWN_WAIT,
        S_SEARCH,
        S_SLAST,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_status = ST_OK;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next  = S_FINISH;
                cmd.res_set = 1'b1;
                case (stat.req)
                    REQ_APPEND: begin
                        if (stat.full) begin
                            cmd.res_status = ST_FULL;
                        end else begin
                            cmd.append = 1'b1;
                        end
                    end
                    REQ_INSERT: begin
                        if (stat.full) begin
                            cmd.res_status = ST_FULL;
                        end else if (stat.ins_bad) begin
                            cmd.res_status = ST_BADPOS;
                        end else if (stat.ins_moves) begin
                            cmd.res_set  = 1'b0;
                            cmd.init_up  = 1'b1;
                            state_next   = S_UP;
                        end else begin
                            cmd.res_set  = 1'b0;
                            state_next   = S_PUT;
                        end
                    end
                    REQ_DELETE: begin
                        if (stat.empty) begin
                            cmd.res_status = ST_EMPTY;
                        end else if (stat.del_bad) begin
                            cmd.res_status = ST_BADPOS;
                        end else if (stat.del_moves) begin
                            cmd.res_set   = 1'b0;
                            cmd.init_down = 1'b1;
                            state_next    = S_DOWN;
                        end else begin
                            cmd.dec_cnt = 1'b1;
                        end
                    end
                    default: begin
                        if (stat.empty) begin
                            cmd.res_status = ST_EMPTY;
                        end else begin
                            cmd.res_set     = 1'b0;
                            cmd.init_search = 1'b1;
                            state_next      = S_SEARCH;
                        end
                    end
                endcase
            end
            // move entries up, last one first
            S_UP: begin
                cmd.move_up = 1'b1;
                if (stat.ra_at_pos) begin
                    state_next = S_UP_WAIT;
                end
            end
            S_UP_WAIT: begin
                state_next = S_PUT;
            end
            S_PUT: begin
                cmd.put_new = 1'b1;
                cmd.res_set = 1'b1;
                state_next  = S_FINISH;
            end
            // move entries down, first one first
            S_DOWN: begin
                cmd.move_down = 1'b1;
                if (stat.ra_at_end) begin
                    state_next = S_DOWN_WAIT;
                end
            end
            S_DOWN_WAIT: begin
                cmd.dec_cnt = 1'b1;
                cmd.res_set = 1'b1;
                state_next  = S_FINISH;
            end
            // read one entry per cycle, compare it in the cycle after the read
            S_SEARCH: begin
                if (stat.hit) begin
                    cmd.res_set   = 1'b1;
                    cmd.res_found = 1'b1;
                    state_next    = S_FINISH;
                end else begin
                    cmd.search_read = 1'b1;
                    if (stat.ra_at_end) begin
                        state_next = S_SLAST;
                    end
                end
            end
            S_SLAST: begin
                cmd.res_set = 1'b1;
                state_next  = S_FINISH;
                if (stat.hit) begin
                    cmd.res_found = 1'b1;
                end else begin
                    cmd.res_status = ST_NOTFOUND;
                end
            end
            S_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/array_list_insert_delete_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_insert_delete_search
// Fixed-capacity ordered list of key and payload entries with append, insert,
// delete and first-match search, one result item per request item.
// ----------------------------------------------------------------------------
// channel  direction  contents
// s_*      in         request: kind on tuser, position/key/payload on tdata
// m_*      out        result: status, found position, entry count on tdata
//
// insert moves each entry from the position up one slot, last one first; delete
// moves each entry above the position down one slot, first one first; search
// compares in order up to the count; a shift reads and writes one entry per cycle.
// reset clears the fill count and control; the entry memory is not cleared.
// a finished result waits in the output register while the next request is
// accepted; a new result is held back only while that register is stalled.
// ----------------------------------------------------------------------------
module array_list_insert_delete_search (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // position[4:0], entry_key[36:5], entry_data[68:37]
    input  logic [7:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[2:0], found_position[7:3], entry_count[12:8]
);
    import alid_pkg::*;

    ctrl_cmd_t         cmd;
    dp_stat_t          stat;
    logic [ST_W-1:0]   st_w;
    logic [FND_W-1:0]  fnd_w;
    logic [CNTO_W-1:0] cnt_w;

    // sequencing
    alid_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // storage and result path
    alid_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .in_req   (req_t'(s_tuser[1:0])),
        .in_pos   (s_tdata[4:0]),
        .in_key   (s_tdata[36:5]),
        .in_data  (s_tdata[68:37]),
        .m_ready  (m_tready),
        .m_valid  (m_tvalid),
        .m_status (st_w),
        .m_found  (fnd_w),
        .m_count  (cnt_w)
    );

    // result packing
    assign m_tdata = {3'b000, cnt_w, fnd_w, st_w};

endmodule
